### hw/rtl/d2pc_pkg.sv
// Shared constants and command/status types of the depth to point cloud block.
// No dependencies; imported by the controller, the datapath and the top level.
package d2pc_pkg;

  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int PIX_COUNT    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int PIX_AW       = $clog2(PIX_COUNT);

  // centred coordinate is position minus this offset
  localparam int CX_OFF = FRAME_WIDTH / 2 - 1;
  localparam int CY_OFF = FRAME_HEIGHT / 2 - 1;

  localparam logic [15:0] DEPTH_BAD  = 16'd2047;
  localparam int          Z_BAD      = -1000;
  localparam int          XY_LIMIT   = 600000;
  localparam int          PROD_SHIFT = 20;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 24;
  localparam logic [CFG_AW-1:0] CFG_SHIFT_X   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_SHIFT_Y   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_INV_FOCAL = 2'd2;

  localparam logic [23:0] INV_FOCAL_RST = 24'd28926;

  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the request
    logic addr;      // store write / read index
    logic rd;        // read the frame store
    logic mul1;      // depth times coordinate magnitude
    logic mul2;      // times inverse focal length
    logic emit;      // load result registers, pulse strobe
  } d2pc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_convert;
  } d2pc_status_t;

endpackage

### hw/rtl/d2pc_ctrl.sv
// Sequencing state machine of the depth to point cloud block.
// Depends on d2pc_pkg (command and status types).
module d2pc_ctrl import d2pc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  d2pc_status_t status_i,
  output d2pc_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADDR = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_MUL1 = 3'd3;
  localparam logic [2:0] ST_MUL2 = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd_o.addr = 1'b1;
        state_d    = status_i.is_convert ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

### hw/rtl/d2pc_datapath.sv
// Datapath: configuration registers, depth frame store, index clamp and
// the two-step back-projection multipliers. Depends on d2pc_pkg.
module d2pc_datapath import d2pc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  d2pc_cmd_t            cmd_i,
  output d2pc_status_t         status_o,
  input  logic                 op_i,
  input  logic [8:0]           row_i,
  input  logic [9:0]           column_i,
  input  logic [15:0]          depth_value_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_AW-1:0]    cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_data_i,
  output logic signed [20:0]   point_x_o,
  output logic signed [20:0]   point_y_o,
  output logic signed [16:0]   point_z_o,
  output logic                 point_valid_o,
  output logic                 point_strobe_o
);

  // configuration
  logic signed [10:0] shift_x_q;
  logic signed [9:0]  shift_y_q;
  logic [23:0]        inv_focal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_x_q   <= '0;
      shift_y_q   <= '0;
      inv_focal_q <= INV_FOCAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHIFT_X:   shift_x_q   <= cfg_data_i[10:0];
        CFG_SHIFT_Y:   shift_y_q   <= cfg_data_i[9:0];
        CFG_INV_FOCAL: inv_focal_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request capture
  logic        op_q;
  logic [8:0]  row_q;
  logic [9:0]  col_q;
  logic [15:0] depth_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_i;
      row_q   <= row_i;
      col_q   <= column_i;
      depth_q <= depth_value_i;
    end
  end

  assign status_o.is_convert = (op_q == OP_CONVERT);

  // addressing
  logic [PIX_AW-1:0]        row_base;
  logic signed [PIX_AW:0]   shy_base;
  logic signed [PIX_AW+2:0] idx_sum;
  logic [PIX_AW-1:0]        idx_clamp;
  logic [PIX_AW-1:0]        ridx_q;
  logic                     in_frame;

  assign row_base = PIX_AW'(row_q) * PIX_AW'(FRAME_WIDTH);
  assign shy_base = (PIX_AW+1)'(shift_y_q) * $signed((PIX_AW+1)'(FRAME_WIDTH));
  assign idx_sum  = $signed({3'b000, row_base})
                  + $signed((PIX_AW+3)'(col_q))
                  + (PIX_AW+3)'(shift_x_q)
                  + (PIX_AW+3)'(shy_base);
  assign in_frame = (32'(row_q) < FRAME_HEIGHT) && (32'(col_q) < FRAME_WIDTH);

  always_comb begin
    if (idx_sum < 0) begin
      idx_clamp = '0;
    end else if (idx_sum > $signed((PIX_AW+3)'(PIX_COUNT - 1))) begin
      idx_clamp = PIX_AW'(PIX_COUNT - 1);
    end else begin
      idx_clamp = idx_sum[PIX_AW-1:0];
    end
  end

  // frame store: one write port, one registered read port
  logic [15:0] depth_mem_q [PIX_COUNT];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr && !status_o.is_convert && in_frame) begin
      depth_mem_q[row_base + PIX_AW'(col_q)] <= depth_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr) begin
      ridx_q <= idx_clamp;
    end
    if (cmd_i.rd) begin
      rdata_q <= depth_mem_q[ridx_q];
    end
  end

  // centred coordinates, sign and magnitude
  logic signed [11:0] cx, cy;
  logic [10:0]        mag_x, mag_y;

  assign cx    = $signed({2'b00, col_q}) - $signed(12'(CX_OFF));
  assign cy    = $signed({3'b000, row_q}) - $signed(12'(CY_OFF));
  assign mag_x = cx[11] ? 11'(-cx) : cx[10:0];
  assign mag_y = cy[11] ? 11'(-cy) : cy[10:0];

  // step 1: depth * |c|
  logic [26:0] dm_x_q, dm_y_q;
  logic        neg_x_q, neg_y_q, valid_q;
  logic [15:0] dz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      dm_x_q  <= 27'(rdata_q) * 27'(mag_x);
      dm_y_q  <= 27'(rdata_q) * 27'(mag_y);
      neg_x_q <= cx[11];
      neg_y_q <= cy[11];
      valid_q <= (rdata_q != 16'd0) && (rdata_q != DEPTH_BAD);
      dz_q    <= rdata_q;
    end
  end

  // step 2: times inverse focal length
  logic [50:0] p_x_q, p_y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2) begin
      p_x_q <= 51'(dm_x_q) * 51'(inv_focal_q);
      p_y_q <= 51'(dm_y_q) * 51'(inv_focal_q);
    end
  end

  // floor of the signed quotient, saturated
  function automatic logic signed [20:0] scale_sat(logic [50:0] p, logic neg);
    logic [51:0] r;
    logic [31:0] q;
    logic [20:0] m;
    r = neg ? (52'(p) + 52'((1 << PROD_SHIFT) - 1)) : 52'(p);
    q = r[PROD_SHIFT +: 32];
    m = (q > 32'(XY_LIMIT)) ? 21'(XY_LIMIT) : q[20:0];
    return neg ? $signed(-m) : $signed(m);
  endfunction

  logic strobe_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      point_valid_o <= valid_q;
      if (valid_q) begin
        point_x_o <= scale_sat(p_x_q, neg_x_q);
        point_y_o <= scale_sat(p_y_q, neg_y_q);
        point_z_o <= $signed({1'b0, dz_q});
      end else begin
        point_x_o <= '0;
        point_y_o <= '0;
        point_z_o <= 17'(Z_BAD);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  assign point_strobe_o = strobe_q;

endmodule

### hw/rtl/depth_to_point_cloud.sv
// Top level of the depth to point cloud back-projector.
// Depends on d2pc_pkg, d2pc_ctrl and d2pc_datapath.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-----------------------------------------
//  request   | start && !busy          | op_i, row_i, column_i, depth_value_i
//  result    | point_strobe_o (1 cyc)  | point_x_o, point_y_o, point_z_o,
//            |                         | point_valid_o
//  config    | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// A store request holds busy for the address state after acceptance (store write).
// A convert request runs through index and clamp, store read, depth times
// coordinate, times inverse focal length and result load; the strobe is high in
// the cycle after the last, when busy has already dropped, so the next
// request may be accepted alongside. Reset clears control and configuration;
// the frame store holds no reset value and needs no clearing pass. The result
// side cannot stall: each result is shown for exactly one cycle.
module depth_to_point_cloud import d2pc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request
  input  logic                 start,
  output logic                 busy,
  input  logic                 op_i,
  input  logic [8:0]           row_i,
  input  logic [9:0]           column_i,
  input  logic [15:0]          depth_value_i,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_AW-1:0]    cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_data_i,
  // result
  output logic signed [20:0]   point_x_o,
  output logic signed [20:0]   point_y_o,
  output logic signed [16:0]   point_z_o,
  output logic                 point_valid_o,
  output logic                 point_strobe_o
);

  d2pc_cmd_t    cmd;
  d2pc_status_t status;

  // sequencer: one request in flight at a time
  d2pc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // storage, addressing and arithmetic
  d2pc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .op_i           (op_i),
    .row_i          (row_i),
    .column_i       (column_i),
    .depth_value_i  (depth_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .point_z_o      (point_z_o),
    .point_valid_o  (point_valid_o),
    .point_strobe_o (point_strobe_o)
  );

endmodule

### tb/tb_top.sv
// Self-checking testbench for the depth to point cloud back-projector.
// Depends on d2pc_pkg and depth_to_point_cloud; predicts every point on the side
// and compares it field by field with what the block puts out.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import d2pc_pkg::*;

  // generous ceiling: ~1600 requests plus sender gaps and drains
  localparam int CYCLE_LIMIT = 300000;
  localparam int ROW_MAX     = 511;    // largest value the row port can carry
  localparam int COL_MAX     = 1023;   // largest value the column port can carry
  localparam int PHASES      = 8;
  localparam int PHASE_REQS  = 200;

  typedef struct packed {
    logic signed [20:0] x;
    logic signed [20:0] y;
    logic signed [16:0] z;
    logic               valid;
  } point_t;

  // Mirror of the frame store and registers; predicts the point for every
  // accepted convert request and checks the block's results in order.
  class point_checker;
    logic [15:0] frame_px [PIX_COUNT];
    bit          written  [PIX_COUNT];
    int          written_idx [$];       // pixels stored at least once
    int          shift_x;
    int          shift_y;
    logic [23:0] inv_focal;
    point_t      expected_points [$];
    int          errors;
    int          checked;
    int          invalid_seen;
    int          saturated_seen;

    function new();
      shift_x   = 0;
      shift_y   = 0;
      inv_focal = INV_FOCAL_RST;
      errors    = 0;
      checked   = 0;
      invalid_seen   = 0;
      saturated_seen = 0;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        CFG_SHIFT_X:   shift_x = $signed(data[10:0]);
        CFG_SHIFT_Y:   shift_y = $signed(data[9:0]);
        CFG_INV_FOCAL: inv_focal = data[23:0];
        default: ;
      endcase
    endfunction

    // shifted row-major read index, clamped into the frame
    function int read_index(int row, int col);
      int idx;
      idx = row * FRAME_WIDTH + col + shift_x + shift_y * FRAME_WIDTH;
      if (idx < 0) idx = 0;
      if (idx > PIX_COUNT - 1) idx = PIX_COUNT - 1;
      return idx;
    endfunction

    // floor(d * c * inv_focal / 2^20), held to +-XY_LIMIT
    function logic signed [20:0] scale_coord(logic [15:0] d, int c);
      longint prod;
      longint q;
      prod = longint'(d) * longint'(c) * longint'(inv_focal);
      q = prod >>> PROD_SHIFT;
      if (q > XY_LIMIT) q = XY_LIMIT;
      if (q < -XY_LIMIT) q = -XY_LIMIT;
      return 21'(q);
    endfunction

    function void note_request(logic op, logic [8:0] row, logic [9:0] col,
                               logic [15:0] depth);
      point_t      p;
      int          idx;
      logic [15:0] d;
      if (op == OP_STORE) begin
        // stores outside the frame are dropped
        if (int'(row) < FRAME_HEIGHT && int'(col) < FRAME_WIDTH) begin
          idx = int'(row) * FRAME_WIDTH + int'(col);
          frame_px[idx] = depth;
          if (!written[idx]) begin
            written[idx] = 1'b1;
            written_idx.push_back(idx);
          end
        end
        return;
      end
      d = frame_px[read_index(int'(row), int'(col))];
      if (d == 16'd0 || d == DEPTH_BAD) begin
        p.x     = '0;
        p.y     = '0;
        p.z     = 17'(Z_BAD);
        p.valid = 1'b0;
      end else begin
        // centred coordinates come from row/column as given, not the read index
        p.x     = scale_coord(d, int'(col) - CX_OFF);
        p.y     = scale_coord(d, int'(row) - CY_OFF);
        p.z     = {1'b0, d};
        p.valid = 1'b1;
      end
      expected_points.push_back(p);
    endfunction

    function void check_point(logic signed [20:0] x, logic signed [20:0] y,
                              logic signed [16:0] z, logic valid);
      point_t want;
      if (expected_points.size() == 0) begin
        $error("point result with no convert request outstanding");
        errors++;
        return;
      end
      want = expected_points.pop_front();
      checked++;
      if (x !== want.x) begin
        $error("point_x: expected %0d, got %0d", want.x, x);
        errors++;
      end
      if (y !== want.y) begin
        $error("point_y: expected %0d, got %0d", want.y, y);
        errors++;
      end
      if (z !== want.z) begin
        $error("point_z: expected %0d, got %0d", want.z, z);
        errors++;
      end
      if (valid !== want.valid) begin
        $error("point_valid: expected %0d, got %0d", want.valid, valid);
        errors++;
      end
      if (!want.valid) invalid_seen++;
      if (want.x == XY_LIMIT || want.x == -XY_LIMIT ||
          want.y == XY_LIMIT || want.y == -XY_LIMIT) saturated_seen++;
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                start         = 1'b0;
  logic                busy;
  logic                op_i          = OP_STORE;
  logic [8:0]          row_i         = '0;
  logic [9:0]          column_i      = '0;
  logic [15:0]         depth_value_i = '0;
  logic                cfg_we_i      = 1'b0;
  logic [CFG_AW-1:0]   cfg_idx_i     = CFG_SHIFT_X;
  logic [CFG_DW-1:0]   cfg_data_i    = '0;
  logic signed [20:0]  point_x_o;
  logic signed [20:0]  point_y_o;
  logic signed [16:0]  point_z_o;
  logic                point_valid_o;
  logic                point_strobe_o;

  point_checker sb;
  bit           idle_on;      // random sender gaps enabled
  int           n_store;
  int           n_convert;
  int           n_settings;

  depth_to_point_cloud dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .row_i          (row_i),
    .column_i       (column_i),
    .depth_value_i  (depth_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .point_z_o      (point_z_o),
    .point_valid_o  (point_valid_o),
    .point_strobe_o (point_strobe_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or drops results.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  // Result side: one strobe cycle per point, no back-pressure possible.
  // Read at the rising edge, i.e. the values held through the ending cycle.
  always @(posedge clk_i) begin
    if (rst_ni && point_strobe_o)
      sb.check_point(point_x_o, point_y_o, point_z_o, point_valid_o);
  end

  // Send one request. Called and returning at a falling edge; start stays high
  // into the next call unless a gap is inserted, so back-to-back requests
  // are offered on consecutive cycles.
  task automatic issue(logic op, logic [8:0] row, logic [9:0] col, logic [15:0] depth);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    start         = 1'b1;
    op_i          = op;
    row_i         = row;
    column_i      = col;
    depth_value_i = depth;
    // accepted at the first rising edge that sees busy low
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_request(op, row, col, depth);
    if (op == OP_STORE) n_store++;
    else n_convert++;
    @(negedge clk_i);
  endtask

  // Quiet the request side and let every outstanding point come back; the
  // tail covers a store that gives no result but may still be in flight.
  task automatic wait_idle();
    start = 1'b0;
    while (sb.expected_points.size() != 0 || busy !== 1'b0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Register writes only ever happen with the block drained.
  task automatic apply_settings(int sx, int sy, logic [23:0] inv);
    logic [CFG_AW-1:0] regs [3];
    logic [CFG_DW-1:0] vals [3];
    wait_idle();
    regs = '{CFG_SHIFT_X, CFG_SHIFT_Y, CFG_INV_FOCAL};
    vals = '{CFG_DW'(sx), CFG_DW'(sy), CFG_DW'(inv)};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i   = 1'b1;
      cfg_idx_i  = regs[i];
      cfg_data_i = vals[i];
      sb.set_reg(regs[i], vals[i]);
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
    n_settings++;
  endtask

  // Choose a convert position whose (shifted, clamped) read hits a pixel that
  // was stored since reset. Mix of free random positions, positions aimed at
  // stored pixels (sometimes re-encoded with an out-of-frame column), and a
  // corner fallback; pixel 0 and the last pixel are stored up front, and one
  // of them is always reachable.
  function automatic void pick_convert(output logic [8:0] row, output logic [9:0] col);
    int r;
    int c;
    int t;
    int s;
    int tries;
    bit ok;
    s     = sb.shift_x + sb.shift_y * FRAME_WIDTH;
    ok    = 1'b0;
    tries = 0;
    r     = 0;
    c     = 0;
    while (!ok) begin
      t = 0;
      if (tries < 64 && $urandom_range(0, 1) == 1) begin
        r = ($urandom_range(0, 4) == 0) ? $urandom_range(0, ROW_MAX)
                                        : $urandom_range(0, FRAME_HEIGHT - 1);
        c = ($urandom_range(0, 4) == 0) ? $urandom_range(0, COL_MAX)
                                        : $urandom_range(0, FRAME_WIDTH - 1);
      end else begin
        if (tries >= 64)
          t = (s > 0 && s < PIX_COUNT - 1) ? PIX_COUNT - 1 - s : 0;
        else
          t = sb.written_idx[$urandom_range(0, sb.written_idx.size() - 1)] - s;
        r = t / FRAME_WIDTH;
        c = t % FRAME_WIDTH;
        // same raw index, one row up and a column past the frame edge
        if (r > ROW_MAX || (r > 0 && c <= COL_MAX - FRAME_WIDTH &&
                            $urandom_range(0, 3) == 0)) begin
          r--;
          c += FRAME_WIDTH;
        end
      end
      ok = t >= 0 && r >= 0 && r <= ROW_MAX && c >= 0 && c <= COL_MAX &&
           sb.written[sb.read_index(r, c)];
      tries++;
    end
    row = 9'(r);
    col = 10'(c);
  endfunction

  initial begin
    logic [8:0]  row;
    logic [9:0]  col;
    logic [15:0] depth;
    int          widx;

    sb         = new();
    idle_on    = 1'b1;
    n_store    = 0;
    n_convert  = 0;
    n_settings = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // ---- directed part, reset register values ----
    issue(OP_STORE, 9'd0,   10'd0,   16'd1000);   // frame corner, clamp target low
    issue(OP_STORE, 9'd479, 10'd639, 16'hFFFF);   // far corner, clamp target high
    issue(OP_STORE, 9'd0,   10'd639, DEPTH_BAD);  // invalid marker depth
    issue(OP_STORE, 9'd479, 10'd0,   16'd1);      // smallest valid depth
    issue(OP_STORE, 9'd239, 10'd319, 16'd1234);   // optical centre: zero x and y
    issue(OP_STORE, 9'd240, 10'd320, 16'd0);      // zero depth, invalid
    issue(OP_STORE, 9'd100, 10'd100, 16'hAAAA);
    issue(OP_STORE, 9'd200, 10'd500, 16'h5555);
    issue(OP_STORE, 9'd0,   10'd5,   16'd777);    // target of the shifted read
    issue(OP_STORE, 9'd511, 10'd1023, 16'hFFFF);  // outside the frame, dropped
    issue(OP_STORE, 9'd100, 10'd700, 16'h1234);   // column outside, dropped

    issue(OP_CONVERT, 9'd0,   10'd0,   16'hFFFF); // negative coords, floor rounding
    issue(OP_CONVERT, 9'd479, 10'd639, 16'd0);
    issue(OP_CONVERT, 9'd0,   10'd639, 16'd0);
    issue(OP_CONVERT, 9'd479, 10'd0,   16'd0);
    issue(OP_CONVERT, 9'd239, 10'd319, 16'd0);
    issue(OP_CONVERT, 9'd240, 10'd320, 16'd0);
    issue(OP_CONVERT, 9'd100, 10'd100, 16'd0);
    issue(OP_CONVERT, 9'd200, 10'd500, 16'd0);
    issue(OP_CONVERT, 9'd511, 10'd1023, 16'd0);   // clamps high, x saturates
    issue(OP_CONVERT, 9'd480, 10'd0,   16'd0);    // one past the last pixel

    // shifted read and saturation both ways at the largest inverse focal
    apply_settings(5, -2, 24'hFFFFFF);
    issue(OP_CONVERT, 9'd2,   10'd0,   16'd0);    // reads pixel (0,5), -limit
    issue(OP_CONVERT, 9'd481, 10'd639, 16'd0);    // clamps high, +limit

    // ---- random part: register extremes first, then random settings ----
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_settings(1023, 511, 24'hFFFFFF);  // every read clamps high
        1: apply_settings(-1024, -512, 24'd1);     // every read clamps low
        2: apply_settings(0, 0, INV_FOCAL_RST);
        default:
          apply_settings(int'($urandom_range(0, 200)) - 100,
                         int'($urandom_range(0, 60)) - 30,
                         ($urandom_range(0, 1) == 1) ?
                           24'($urandom_range(1, 24'hFFFFFF)) :
                           24'($urandom_range(20000, 60000)));
      endcase
      // last stretch runs back to back
      idle_on = (ph != PHASES - 1);

      for (int i = 0; i < PHASE_REQS; i++) begin
        if ($urandom_range(0, 99) < 45) begin
          case ($urandom_range(0, 9))
            0:       depth = 16'd0;
            1:       depth = DEPTH_BAD;
            2:       depth = 16'hFFFF;
            3:       depth = ($urandom_range(0, 1) == 1) ? DEPTH_BAD + 16'd1
                                                         : DEPTH_BAD - 16'd1;
            default: depth = 16'($urandom_range(1, 16'hFFFF));
          endcase
          case ($urandom_range(0, 9))
            0: begin
              // anywhere the ports reach, often outside the frame
              row = 9'($urandom_range(0, ROW_MAX));
              col = 10'($urandom_range(0, COL_MAX));
            end
            1, 2: begin
              // overwrite a stored pixel
              widx = sb.written_idx[$urandom_range(0, sb.written_idx.size() - 1)];
              row  = 9'(widx / FRAME_WIDTH);
              col  = 10'(widx % FRAME_WIDTH);
            end
            default: begin
              row = 9'($urandom_range(0, FRAME_HEIGHT - 1));
              col = 10'($urandom_range(0, FRAME_WIDTH - 1));
            end
          endcase
          issue(OP_STORE, row, col, depth);
        end else begin
          pick_convert(row, col);
          issue(OP_CONVERT, row, col, 16'($urandom));
        end
      end
    end

    wait_idle();
    $display("Checked %0d points from %0d stores and %0d converts across %0d register settings.",
             sb.checked, n_store, n_convert, n_settings);
    $display("Of these, %0d came from invalid depths and %0d reached the coordinate limit.",
             sb.invalid_seen, sb.saturated_seen);
    if (sb.errors == 0 && sb.expected_points.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
